>>> hdl/ipf_pkg.sv
// Shared types and constants for the in-circle point filter.
package ipf_pkg;

	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_A_X = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_A_Y = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_B_X = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_B_Y = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_C_X = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_C_Y = 3'd5;

	typedef struct packed {
		logic s4;
		logic s5;
	} ipf_stall_t;

endpackage

>>> hdl/ipf_point_if.sv
// Valid/ready channel interfaces for candidate points and filter results.
interface ipf_point_if #(
	parameter int COORD_BITS = 16,
	parameter int ID_BITS    = 20
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic        [ID_BITS-1:0]    point_id;
	logic                         active_in;
	logic                         last_in_batch;

	modport source (output valid, point_x, point_y, point_id, active_in, last_in_batch,
		input ready);
	modport sink (input valid, point_x, point_y, point_id, active_in, last_in_batch,
		output ready);
endinterface

interface ipf_result_if #(
	parameter int ID_BITS = 20
) ();
	logic               valid;
	logic               ready;
	logic [ID_BITS-1:0] point_id_out;
	logic               keep;
	logic               last_out;

	modport source (output valid, point_id_out, keep, last_out, input ready);
	modport sink (input valid, point_id_out, keep, last_out, output ready);
endinterface

>>> hdl/ipf_split_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
module ipf_split_mul #(
	parameter int W = 35
) (
	input  logic                    clk,
	input  ipf_pkg::ipf_stall_t     en,
	input  logic signed [W-1:0]     a,
	input  logic signed [W-1:0]     b,
	output logic signed [2*W-1:0]   prod_s5
);
	import ipf_pkg::*;

	localparam int H  = (W + 1) / 2;
	localparam int HW = W - H;
	localparam int PW = 2 * W;

	logic signed [HW-1:0]   ah, bh;
	logic        [H-1:0]    al, bl;
	logic signed [H:0]      alx, blx;
	logic signed [2*HW-1:0] hh;
	logic signed [W:0]      hl, lh;
	logic        [2*H-1:0]  ll;

	logic signed [2*HW-1:0] hh_s4;
	logic signed [W:0]      hl_s4, lh_s4;
	logic        [2*H-1:0]  ll_s4;

	logic signed [PW-1:0]   t_hh, t_hl, t_lh, t_ll;

	assign ah  = a[W-1:H];
	assign bh  = b[W-1:H];
	assign al  = a[H-1:0];
	assign bl  = b[H-1:0];
	assign alx = $signed({1'b0, al});
	assign blx = $signed({1'b0, bl});

	always_comb begin
		hh = ah * bh;
		hl = ah * blx;
		lh = alx * bh;
		ll = al * bl;
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			hh_s4 <= hh;
			hl_s4 <= hl;
			lh_s4 <= lh;
			ll_s4 <= ll;
		end
	end

	assign t_hh = {hh_s4, {(2*H){1'b0}}};
	assign t_hl = {{(HW-1){hl_s4[W]}}, hl_s4, {H{1'b0}}};
	assign t_lh = {{(HW-1){lh_s4[W]}}, lh_s4, {H{1'b0}}};
	assign t_ll = $signed({{(PW-2*H){1'b0}}, ll_s4});

	always_ff @(posedge clk) begin
		if (en.s5) begin
			prod_s5 <= t_hh + t_hl + t_lh + t_ll;
		end
	end

endmodule

>>> hdl/incircle_point_filter.sv
// Top level of the streaming in-circle point filter.
//
// Write the triangle's six vertex coordinates through cfg_we/cfg_idx/cfg_wdata
// (a, b, c as x then y, indexes 0..5) while the pipeline is empty; other
// indexes are ignored. Points enter on the point channel, one beat per cycle
// while point.ready is high; each yields one beat on the result channel
// carrying its id, the keep flag (active and strictly inside the circumcircle
// of a counterclockwise triangle) and the batch end mark.
// The pipeline has six register stages, s1 to s6, and the result is taken from
// s6; throughput is one point per cycle, since every stage takes a new beat in
// each cycle that the result side is not stalled.
// Each stage advances when it is empty or the stage after it moves, so
// empty slots fill while the result is stalled; a full pipeline holds its
// beats and drops point.ready until result.ready returns.
// Reset clears all vertex registers to zero and empties the pipeline.
module incircle_point_filter #(
	parameter int ID_BITS    = 20,
	parameter int COORD_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ipf_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [COORD_BITS-1:0]              cfg_wdata,
	ipf_point_if.sink                          point,
	ipf_result_if.source                       result
);
	import ipf_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int W  = 2 * C + 3;
	localparam int PW = 2 * W;
	localparam int DW = PW + 2;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic               act;
		logic               last;
	} tag_t;

	logic signed [C-1:0] va_x_q, va_y_q, vb_x_q, vb_y_q, vc_x_q, vc_y_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;

	logic signed [C:0] xa_s1, ya_s1, xb_s1, yb_s1, xc_s1, yc_s1;

	logic signed [2*C+1:0] xaa_s2, yaa_s2, xbb_s2, ybb_s2, xcc_s2, ycc_s2;
	logic signed [2*C+1:0] xbyc_s2, xcyb_s2, xayc_s2, xcya_s2, xayb_s2, xbya_s2;

	logic signed [W-1:0] sa_s3, sb_s3, sc_s3, m1_s3, m2_s3, m3_s3;

	logic signed [PW-1:0] p1_s5, p2_s5, p3_s5;
	logic signed [DW-1:0] det;
	logic                 keep_s6;
	ipf_stall_t           mul_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_x_q <= '0;
			va_y_q <= '0;
			vb_x_q <= '0;
			vb_y_q <= '0;
			vc_x_q <= '0;
			vc_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_A_X: va_x_q <= cfg_wdata;
				REG_A_Y: va_y_q <= cfg_wdata;
				REG_B_X: vb_x_q <= cfg_wdata;
				REG_B_Y: vb_y_q <= cfg_wdata;
				REG_C_X: vc_x_q <= cfg_wdata;
				REG_C_Y: vc_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en_s6 = !v_s6 || result.ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign point.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= point.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// vertex minus point
	always_ff @(posedge clk) begin
		if (en_s1) begin
			tag_s1 <= '{id: point.point_id, act: point.active_in, last: point.last_in_batch};
			xa_s1  <= {va_x_q[C-1], va_x_q} - {point.point_x[C-1], point.point_x};
			ya_s1  <= {va_y_q[C-1], va_y_q} - {point.point_y[C-1], point.point_y};
			xb_s1  <= {vb_x_q[C-1], vb_x_q} - {point.point_x[C-1], point.point_x};
			yb_s1  <= {vb_y_q[C-1], vb_y_q} - {point.point_y[C-1], point.point_y};
			xc_s1  <= {vc_x_q[C-1], vc_x_q} - {point.point_x[C-1], point.point_x};
			yc_s1  <= {vc_y_q[C-1], vc_y_q} - {point.point_y[C-1], point.point_y};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			tag_s2  <= tag_s1;
			xaa_s2  <= xa_s1 * xa_s1;
			yaa_s2  <= ya_s1 * ya_s1;
			xbb_s2  <= xb_s1 * xb_s1;
			ybb_s2  <= yb_s1 * yb_s1;
			xcc_s2  <= xc_s1 * xc_s1;
			ycc_s2  <= yc_s1 * yc_s1;
			xbyc_s2 <= xb_s1 * yc_s1;
			xcyb_s2 <= xc_s1 * yb_s1;
			xayc_s2 <= xa_s1 * yc_s1;
			xcya_s2 <= xc_s1 * ya_s1;
			xayb_s2 <= xa_s1 * yb_s1;
			xbya_s2 <= xb_s1 * ya_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			tag_s3 <= tag_s2;
			sa_s3  <= {xaa_s2[2*C+1], xaa_s2} + {yaa_s2[2*C+1], yaa_s2};
			sb_s3  <= {xbb_s2[2*C+1], xbb_s2} + {ybb_s2[2*C+1], ybb_s2};
			sc_s3  <= {xcc_s2[2*C+1], xcc_s2} + {ycc_s2[2*C+1], ycc_s2};
			m1_s3  <= {xbyc_s2[2*C+1], xbyc_s2} - {xcyb_s2[2*C+1], xcyb_s2};
			m2_s3  <= {xayc_s2[2*C+1], xayc_s2} - {xcya_s2[2*C+1], xcya_s2};
			m3_s3  <= {xayb_s2[2*C+1], xayb_s2} - {xbya_s2[2*C+1], xbya_s2};
		end
	end

	assign mul_en = '{s4: en_s4, s5: en_s5};

	ipf_split_mul #(.W(W)) u_mul_a (
		.clk     (clk),
		.en      (mul_en),
		.a       (sa_s3),
		.b       (m1_s3),
		.prod_s5 (p1_s5)
	);

	ipf_split_mul #(.W(W)) u_mul_b (
		.clk     (clk),
		.en      (mul_en),
		.a       (sb_s3),
		.b       (m2_s3),
		.prod_s5 (p2_s5)
	);

	ipf_split_mul #(.W(W)) u_mul_c (
		.clk     (clk),
		.en      (mul_en),
		.a       (sc_s3),
		.b       (m3_s3),
		.prod_s5 (p3_s5)
	);

	always_ff @(posedge clk) begin
		if (en_s4) tag_s4 <= tag_s3;
		if (en_s5) tag_s5 <= tag_s4;
	end

	assign det = {{2{p1_s5[PW-1]}}, p1_s5} - {{2{p2_s5[PW-1]}}, p2_s5}
		+ {{2{p3_s5[PW-1]}}, p3_s5};

	always_ff @(posedge clk) begin
		if (en_s6) begin
			tag_s6  <= tag_s5;
			keep_s6 <= tag_s5.act && !det[DW-1] && (|det);
		end
	end

	assign result.valid        = v_s6;
	assign result.point_id_out = tag_s6.id;
	assign result.keep         = keep_s6;
	assign result.last_out     = tag_s6.last;

endmodule

>>> dv/incircle_point_filter_tb.sv
// Self-checking testbench for incircle_point_filter: directed and random point streams.
module incircle_point_filter_tb;
	import ipf_pkg::*;

	localparam int COORD_W      = 16;
	localparam int ID_W         = 20;
	localparam int COORD_MAX    = 32767;
	localparam int COORD_MIN    = -32768;
	localparam int PIPE_LATENCY = 6;
	localparam int DRAIN_PAD    = 4 * PIPE_LATENCY;
	localparam int LONG_HOLD    = 80;
	localparam int QUIET_LIMIT  = 1000;
	localparam int MAX_REPORTS  = 10;

	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            keep;
		logic            last;
	} verdict_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_idx;
	logic [COORD_W-1:0]      cfg_wdata;

	ipf_point_if #(.COORD_BITS(COORD_W), .ID_BITS(ID_W)) point_ch ();
	ipf_result_if #(.ID_BITS(ID_W)) result_ch ();

	incircle_point_filter #(
		.ID_BITS(ID_W),
		.COORD_BITS(COORD_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.point(point_ch),
		.result(result_ch)
	);

	coord_t   vert_x [3];
	coord_t   vert_y [3];
	verdict_t verdicts_due [$];
	int       error_count = 0;
	int       quiet_cycles = 0;
	bit       src_gaps = 1'b0;
	bit       sink_gaps = 1'b0;
	bit       hold_req = 1'b0;
	int       hold_left = 0;
	int       cloud_x = 0;
	int       cloud_y = 0;
	int       cloud_r = 64;

	always #10 clk = ~clk;

	function automatic bit in_circumcircle(coord_t px, coord_t py);
		logic signed [127:0] xa, ya, xb, yb, xc, yc;
		logic signed [127:0] sa, sb, sc, m1, m2, m3, det;
		xa = vert_x[0] - px;
		ya = vert_y[0] - py;
		xb = vert_x[1] - px;
		yb = vert_y[1] - py;
		xc = vert_x[2] - px;
		yc = vert_y[2] - py;
		sa = xa * xa + ya * ya;
		sb = xb * xb + yb * yb;
		sc = xc * xc + yc * yc;
		m1 = xb * yc - xc * yb;
		m2 = xa * yc - xc * ya;
		m3 = xa * yb - xb * ya;
		det = sa * m1 - sb * m2 + sc * m3;
		return det > 0;
	endfunction

	function automatic coord_t clamp_coord(int v);
		if (v > COORD_MAX)
			return coord_t'(COORD_MAX);
		if (v < COORD_MIN)
			return coord_t'(COORD_MIN);
		return coord_t'(v);
	endfunction

	task automatic flag_failure(string what);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("ERROR at %0t: %s", $time, what);
	endtask

	// Sample both channels mid-cycle, where every signal is settled.
	always @(negedge clk) begin
		verdict_t due;
		if (arst_n) begin
			if (point_ch.valid && point_ch.ready)
				verdicts_due.push_back(verdict_t'{
					id:   point_ch.point_id,
					keep: point_ch.active_in
						&& in_circumcircle(point_ch.point_x, point_ch.point_y),
					last: point_ch.last_in_batch});
			if (result_ch.valid && result_ch.ready) begin
				if (verdicts_due.size() == 0) begin
					flag_failure($sformatf("result beat with nothing pending: id=%h keep=%b last=%b",
						result_ch.point_id_out, result_ch.keep, result_ch.last_out));
				end else begin
					due = verdicts_due.pop_front();
					if (result_ch.point_id_out !== due.id || result_ch.keep !== due.keep
						|| result_ch.last_out !== due.last)
						flag_failure($sformatf(
							"expected id=%h keep=%b last=%b, got id=%h keep=%b last=%b",
							due.id, due.keep, due.last,
							result_ch.point_id_out, result_ch.keep, result_ch.last_out));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (point_ch.valid && point_ch.ready)
			|| (result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ch.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req <= 1'b0;
			hold_left <= LONG_HOLD - 1;
			result_ch.ready <= 1'b0;
		end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
			hold_left <= $urandom_range(0, 14);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	task automatic send_point(coord_t x, coord_t y, logic [ID_W-1:0] id, bit active, bit last);
		bit took;
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			point_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		point_ch.valid         <= 1'b1;
		point_ch.point_x       <= x;
		point_ch.point_y       <= y;
		point_ch.point_id      <= id;
		point_ch.active_in     <= active;
		point_ch.last_in_batch <= last;
		do begin
			@(negedge clk);
			took = point_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic send_random_point();
		coord_t x, y;
		if ($urandom_range(0, 7) == 0) begin
			x = coord_t'($urandom_range(0, 65535));
			y = coord_t'($urandom_range(0, 65535));
		end else begin
			x = clamp_coord(cloud_x + int'($urandom_range(0, 3 * cloud_r)) - 3 * cloud_r / 2);
			y = clamp_coord(cloud_y + int'($urandom_range(0, 3 * cloud_r)) - 3 * cloud_r / 2);
		end
		send_point(x, y, ID_W'($urandom), $urandom_range(0, 3) != 0, $urandom_range(0, 7) == 0);
	endtask

	task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, coord_t value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_A_X: vert_x[0] = value;
			REG_A_Y: vert_y[0] = value;
			REG_B_X: vert_x[1] = value;
			REG_B_Y: vert_y[1] = value;
			REG_C_X: vert_x[2] = value;
			REG_C_Y: vert_y[2] = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_triangle(coord_t ax, coord_t ay, coord_t bx, coord_t by,
		coord_t cx, coord_t cy);
		cfg_write(REG_A_X, ax);
		cfg_write(REG_A_Y, ay);
		cfg_write(REG_B_X, bx);
		cfg_write(REG_B_Y, by);
		cfg_write(REG_C_X, cx);
		cfg_write(REG_C_Y, cy);
		cfg_we <= 1'b0;
	endtask

	task automatic load_random_triangle();
		int vx [3];
		int vy [3];
		int spread;
		spread = $urandom_range(0, 3);
		case (spread)
			0: cloud_r = $urandom_range(2, 64);
			1: cloud_r = $urandom_range(65, 2048);
			default: cloud_r = $urandom_range(2049, COORD_MAX);
		endcase
		cloud_x = int'($urandom_range(0, 65535)) + COORD_MIN;
		cloud_y = int'($urandom_range(0, 65535)) + COORD_MIN;
		for (int k = 0; k < 3; k++) begin
			vx[k] = cloud_x + int'($urandom_range(0, 2 * cloud_r)) - cloud_r;
			vy[k] = cloud_y + int'($urandom_range(0, 2 * cloud_r)) - cloud_r;
			if ($urandom_range(0, 15) == 0)
				vx[k] = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
			if ($urandom_range(0, 15) == 0)
				vy[k] = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		end
		load_triangle(clamp_coord(vx[0]), clamp_coord(vy[0]), clamp_coord(vx[1]),
			clamp_coord(vy[1]), clamp_coord(vx[2]), clamp_coord(vy[2]));
	endtask

	// Drop valid, wait out every pending result, then let the pipeline settle.
	task automatic finish_phase();
		point_ch.valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// Vertices all at the origin after reset: nothing can be kept.
	task automatic test_reset_state();
		send_point(coord_t'(COORD_MIN), coord_t'(COORD_MIN), '0, 1'b1, 1'b0);
		send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), '1, 1'b1, 1'b0);
		send_point(16'sd0, 16'sd0, 20'h12345, 1'b1, 1'b1);
		finish_phase();
	endtask

	task automatic test_directed_geometry();
		load_triangle(16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd100);
		send_point(16'sd10, 16'sd10, 20'h00001, 1'b1, 1'b0);
		send_point(16'sd10, 16'sd10, 20'h00002, 1'b0, 1'b0);
		send_point(16'sd100, 16'sd100, 20'h00003, 1'b1, 1'b0);
		send_point(16'sd0, 16'sd0, 20'h00004, 1'b1, 1'b0);
		send_point(16'sd200, 16'sd200, 20'h00005, 1'b1, 1'b0);
		send_point(-16'sd40, 16'sd50, 20'h00006, 1'b1, 1'b1);
		finish_phase();
		// clockwise: inside and outside swap roles
		load_triangle(16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'sd0);
		send_point(16'sd10, 16'sd10, 20'h00007, 1'b1, 1'b0);
		send_point(16'sd200, 16'sd200, 20'h00008, 1'b1, 1'b1);
		finish_phase();
		// degenerate: collinear vertices
		load_triangle(-16'sd50, -16'sd50, 16'sd0, 16'sd0, 16'sd50, 16'sd50);
		send_point(16'sd10, -16'sd10, 20'h00009, 1'b1, 1'b0);
		send_point(-16'sd10, 16'sd10, 20'h0000A, 1'b1, 1'b1);
		finish_phase();
	endtask

	task automatic test_extreme_triangle();
		load_triangle(coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MAX),
			coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MAX));
		send_point(16'sd0, 16'sd0, 20'hFFFFF, 1'b1, 1'b0);
		send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), 20'hAAAAA, 1'b1, 1'b0);
		send_point(coord_t'(COORD_MIN), coord_t'(COORD_MAX), 20'h55555, 1'b1, 1'b0);
		send_point(coord_t'(COORD_MAX), -16'sd32767, 20'h80000, 1'b1, 1'b0);
		send_point(coord_t'(COORD_MIN), coord_t'(COORD_MIN), 20'h7FFFF, 1'b1, 1'b1);
		finish_phase();
	endtask

	task automatic test_ignored_index();
		load_triangle(16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd100);
		@(posedge clk);
		cfg_write(REG_SPARE_6, coord_t'(COORD_MIN));
		cfg_write(REG_SPARE_7, coord_t'(COORD_MAX));
		cfg_we <= 1'b0;
		send_point(16'sd10, 16'sd10, 20'h0000B, 1'b1, 1'b0);
		send_point(16'sd200, 16'sd200, 20'h0000C, 1'b1, 1'b1);
		finish_phase();
	endtask

	task automatic test_random_triangles(int phases, int per_phase);
		src_gaps  <= 1'b1;
		sink_gaps <= 1'b1;
		for (int p = 0; p < phases; p++) begin
			load_random_triangle();
			repeat (per_phase) send_random_point();
			finish_phase();
		end
	endtask

	// Hold the result side off while points keep coming, so the input stalls.
	task automatic test_backpressure(int count);
		src_gaps  <= 1'b0;
		sink_gaps <= 1'b0;
		hold_req  <= 1'b1;
		repeat (count) send_random_point();
		finish_phase();
	endtask

	task automatic test_steady_stream(int count);
		src_gaps  <= 1'b0;
		sink_gaps <= 1'b0;
		load_random_triangle();
		repeat (count) send_random_point();
		finish_phase();
	endtask

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_idx                = '0;
		cfg_wdata              = '0;
		point_ch.valid         = 1'b0;
		point_ch.point_x       = '0;
		point_ch.point_y       = '0;
		point_ch.point_id      = '0;
		point_ch.active_in     = 1'b0;
		point_ch.last_in_batch = 1'b0;
		for (int k = 0; k < 3; k++) begin
			vert_x[k] = '0;
			vert_y[k] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_geometry();
		test_extreme_triangle();
		test_ignored_index();
		test_random_triangles(10, 80);
		test_backpressure(100);
		test_steady_stream(250);

		if (verdicts_due.size() != 0)
			flag_failure($sformatf("%0d results never arrived", verdicts_due.size()));
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
